/* sv/dbsj_pkg.sv */
// shared types and constants for the der bit string segment joiner
// no dependencies; every other file of the block depends on this package
`default_nettype none

package dbsj_pkg;

   localparam int BYTE_W      = 8;
   localparam int FILL_W      = 4;   // holds 0 to 8 packed bits
   localparam int UNUSED_W    = 3;
   localparam int RSP_DEPTH_D = 4;   // default result queue depth

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              is_lead;
      logic              seg_end;
      logic              final_req;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                last;
      logic [UNUSED_W-1:0] unused_bits;
      logic                error;
   } result_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   partial_byte;
      logic [FILL_W-1:0]   filled_bits;
      logic [UNUSED_W-1:0] segment_unused;
      logic                segment_open;
      logic                error_seen;
   } state_type;

endpackage

`default_nettype wire

/* sv/dbsj_if.sv */
// valid/ready channel interfaces of the joiner: input items, results, configuration
// depends on dbsj_pkg for the field widths
`default_nettype none

interface dbsj_req_if;
   logic                       valid;
   logic                       ready;
   logic [dbsj_pkg::BYTE_W-1:0] in_byte;
   logic                       is_lead;
   logic                       seg_end;
   logic                       final_req;

   modport source (output valid, in_byte, is_lead, seg_end, final_req, input ready);
   modport sink   (input valid, in_byte, is_lead, seg_end, final_req, output ready);
endinterface

interface dbsj_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dbsj_pkg::BYTE_W-1:0]   out_byte;
   logic                         last;
   logic [dbsj_pkg::UNUSED_W-1:0] unused_bits;
   logic                         error;

   modport source (output valid, out_byte, last, unused_bits, error, input ready);
   modport sink   (input valid, out_byte, last, unused_bits, error, output ready);
endinterface

interface dbsj_csr_if;
   logic valid;
   logic ready;
   logic strict_mode;

   modport source (output valid, strict_mode, input ready);
   modport sink   (input valid, strict_mode, output ready);
endinterface

`default_nettype wire

/* sv/dbsj_pack.sv */
// bit packer of the joiner: next stream state and up to two result bytes for one item
// depends on dbsj_pkg
`default_nettype none

module dbsj_pack (
   input  dbsj_pkg::state_type  st,
   input  dbsj_pkg::item_type   item,
   input  logic                 strict_mode,
   output dbsj_pkg::state_type  st_n,
   output logic [1:0]           res_count,
   output dbsj_pkg::result_type res0,
   output dbsj_pkg::result_type res1
);
   import dbsj_pkg::*;

   logic                  ends;
   logic                  err;
   logic [UNUSED_W-1:0]   su;
   logic [BYTE_W-1:0]     mask;
   logic [BYTE_W-1:0]     data;
   logic [2*BYTE_W-1:0]   acc;
   logic [FILL_W:0]       take;
   logic [FILL_W:0]       sum;
   result_type            fin;

   always_comb begin
      st_n      = st;
      res_count = 2'd0;
      res0      = '0;
      res1      = '0;
      err       = 1'b0;
      su        = '0;
      mask      = '1;
      data      = '0;
      acc       = '0;
      take      = '0;
      sum       = '0;
      fin       = '0;
      ends      = item.seg_end | item.final_req;

      if (item.is_lead) begin
         err = st.segment_open;
         if (item.in_byte[BYTE_W-1:UNUSED_W] != '0) begin
            err                 = 1'b1;
            st_n.segment_unused = '0;
         end else begin
            st_n.segment_unused = item.in_byte[UNUSED_W-1:0];
         end
         st_n.segment_open = 1'b1;
         if (ends) begin
            if (item.in_byte != '0) begin
               err = 1'b1;
            end
            st_n.segment_open = 1'b0;
         end
      end else begin
         // data with no open segment starts an implicit one with no unused bits and sets the error flag
         su  = st.segment_open ? st.segment_unused : '0;
         err = ~st.segment_open;
         if (ends && strict_mode && !item.final_req && su != '0) begin
            err = 1'b1;
         end
         mask = ends ? (BYTE_W'('1) << su) : '1;
         data = item.in_byte & mask;
         take = ends ? ((FILL_W+1)'(BYTE_W) - (FILL_W+1)'(su)) : (FILL_W+1)'(BYTE_W);
         acc  = {st.partial_byte, {BYTE_W{1'b0}}}
              | ({data, {BYTE_W{1'b0}}} >> st.filled_bits);
         sum  = (FILL_W+1)'(st.filled_bits) + take;
         if (sum <= (FILL_W+1)'(BYTE_W)) begin
            st_n.partial_byte = acc[2*BYTE_W-1:BYTE_W];
            st_n.filled_bits  = sum[FILL_W-1:0];
         end else begin
            res0.out_byte     = acc[2*BYTE_W-1:BYTE_W];
            res_count         = 2'd1;
            st_n.partial_byte = acc[BYTE_W-1:0];
            st_n.filled_bits  = FILL_W'(sum - (FILL_W+1)'(BYTE_W));
         end
         st_n.segment_unused = su;
         st_n.segment_open   = ~ends;
      end

      st_n.error_seen = st.error_seen | err;

      if (item.final_req) begin
         fin.last  = 1'b1;
         fin.error = st_n.error_seen;
         if (st_n.filled_bits != '0) begin
            fin.out_byte    = st_n.partial_byte;
            fin.unused_bits = UNUSED_W'(FILL_W'(BYTE_W) - st_n.filled_bits);
         end
         if (res_count == 2'd0) begin
            res0 = fin;
         end else begin
            res1 = fin;
         end
         res_count = res_count + 2'd1;
         // string done: next item opens a new one
         st_n = '0;
      end
   end

endmodule

`default_nettype wire

/* sv/der_bitstring_segment_joiner.sv */
// top level of the der bit string segment joiner: input register, packer, result queue
// depends on dbsj_pkg, dbsj_if and dbsj_pack
`default_nettype none

// Joins the payloads of consecutive DER bit string segments into one packed byte
// stream, MSB first, dropping each segment's unused trailing bits. An item is one
// payload byte; is_lead marks a segment's unused-bit count, seg_end closes a segment
// and final_req closes the string, which then gives its last byte with the unused
// bit count and the sticky error flag (a single zero byte when nothing was packed).
// One item is taken per clock while the result queue has room: it is held in an input
// register and the packer writes zero, one or two result bytes into a result queue of
// RSP_DEPTH entries, whose head drives the rsp_ port. A result passes through the
// input register and then the result queue before it shows on the rsp_ port.
// The input register advances only while the queue has room for two results, so
// items that each produce two bytes are taken at the rate the result side drains,
// one byte per cycle. strict_mode may be written whenever the block is idle.
module der_bitstring_segment_joiner #(
   parameter int RSP_DEPTH = dbsj_pkg::RSP_DEPTH_D
) (
   input  logic       clock,
   input  logic       reset,
   dbsj_req_if.sink   req_bus,
   dbsj_rsp_if.source rsp_bus,
   dbsj_csr_if.sink   csr_bus
);
   import dbsj_pkg::*;

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   logic                  strict_ff;
   logic                  in_valid_ff;
   item_type              item_ff;
   state_type             st_ff;
   state_type             st_n;
   logic [1:0]            res_count;
   result_type            res0;
   result_type            res1;
   result_type            q_ff [RSP_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      wr_nxt;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  room;
   logic                  advance;
   logic                  pop;
   logic [1:0]            push_n;
   item_type              req_item;
   result_type            head;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(RSP_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   dbsj_pack u_pack (
      .st          (st_ff),
      .item        (item_ff),
      .strict_mode (strict_ff),
      .st_n        (st_n),
      .res_count   (res_count),
      .res0        (res0),
      .res1        (res1)
   );

   assign req_item.in_byte   = req_bus.in_byte;
   assign req_item.is_lead   = req_bus.is_lead;
   assign req_item.seg_end   = req_bus.seg_end;
   assign req_item.final_req = req_bus.final_req;

   // room for two results whatever the result side does this cycle
   assign room          = count_ff <= CNT_W'(RSP_DEPTH - 2);
   assign advance       = in_valid_ff & room;
   assign req_bus.ready = ~in_valid_ff | room;
   assign csr_bus.ready = 1'b1;

   assign head                = q_ff[rd_ptr_ff];
   assign rsp_bus.valid       = count_ff != '0;
   assign rsp_bus.out_byte    = head.out_byte;
   assign rsp_bus.last        = head.last;
   assign rsp_bus.unused_bits = head.unused_bits;
   assign rsp_bus.error       = head.error;

   assign pop    = rsp_bus.valid & rsp_bus.ready;
   assign push_n = advance ? res_count : 2'd0;
   assign wr_nxt = ptr_inc(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_n == 2'd1) begin
         wr_ptr_in = wr_nxt;
      end else if (push_n == 2'd2) begin
         wr_ptr_in = ptr_inc(wr_nxt);
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff   <= 1'b0;
         in_valid_ff <= 1'b0;
         st_ff       <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_bus.valid) begin
            strict_ff <= csr_bus.strict_mode;
         end
         if (req_bus.valid && req_bus.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            st_ff <= st_n;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         item_ff <= req_item;
      end
      if (push_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_nxt] <= res1;
      end
   end

endmodule

`default_nettype wire
